// ----- sv/apgi_pkg.sv -----
// Shared constants, codes and helper functions of the antenna phase-center
// variation grid interpolator. Used by the top level.
// No dependencies.
`default_nettype none

package apgi_pkg;

    // Default table geometry
    localparam int NUM_BANDS_DEF = 16;
    localparam int ENTRIES_DEF   = 2048;

    // Field widths
    localparam int BAND_W = 4;
    localparam int IDX_W  = 11;
    localparam int VAL_W  = 16;
    localparam int AZ_W   = 17;
    localparam int ZE_W   = 15;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 17;

    // Divider lanes: one quotient bit per stage
    localparam int DQ_W = 17;
    // Final rounding divider: quotient bits and dividend width
    localparam int FQ_W = 17;
    localparam int FN_W = 50;

    // Angle constants, 1/256 degree
    localparam logic [AZ_W-1:0] FULL_TURN = 17'd92160;
    localparam logic [ZE_W-1:0] LIN_STEP  = 15'd1280;
    localparam logic [4:0]      LIN_LAST  = 5'd18;

    // Register reset values
    localparam logic [ZE_W-1:0] ZS_RST    = 15'd0;
    localparam logic [ZE_W-1:0] ZE_RST    = 15'd23040;
    localparam logic [ZE_W-1:0] ZSTEP_RST = 15'd1280;
    localparam logic [AZ_W-1:0] ASTEP_RST = 17'd1280;

    // Offset that makes the rounding dividend nonnegative (32768 + 1)
    localparam logic signed [17:0] Q_OFFSET = 18'sd32769;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ZENITH_START = 3'd0,
        CFG_ZENITH_END   = 3'd1,
        CFG_ZENITH_STEP  = 3'd2,
        CFG_AZIMUTH_STEP = 3'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // x / 5 for x below 128, by reciprocal multiply
    function automatic logic [4:0] div5(input logic [6:0] x);
        logic [14:0] p;
        begin
            p = 15'(x) * 15'd205;
            return p[14:10];
        end
    endfunction

    // One restoring division step: returns {remainder, quotient}
    function automatic logic [2*DQ_W-1:0] div_step(
        input logic [DQ_W-1:0] a,
        input logic [DQ_W-1:0] q,
        input logic [DQ_W-1:0] d
    );
        logic [DQ_W:0]   t;
        logic [DQ_W-1:0] na;
        logic [DQ_W-1:0] nq;
        begin
            t = {a, q[DQ_W-1]};
            if (t >= {1'b0, d}) begin
                na = DQ_W'(t - {1'b0, d});
                nq = {q[DQ_W-2:0], 1'b1};
            end else begin
                na = t[DQ_W-1:0];
                nq = {q[DQ_W-2:0], 1'b0};
            end
            return {na, nq};
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/apgi_ram.sv -----
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module apgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- sv/antenna_pcv_grid_interpolator.sv -----
// Top level of the antenna phase-center variation grid interpolator.
// Depends on apgi_pkg and apgi_ram.
//
// Usage:
//  - Input channel (i_valid / o_stall): one item per transfer. A write item
//    (operation 0) stores entry_value at band/entry_index; a query item
//    (operation 1) returns one result. Writes give no result.
//  - Output channel (o_valid / i_stall): correction and status per query.
//  - Configuration channel (i_cfg_valid / o_cfg_ready): ready is always
//    high; write registers only while no item is in flight.
//  - Throughput: one item per cycle unless the input is stalled. Path: a
//    query result passes through two bit-per-stage dividers (18 registers
//    each: cell index, rounding) plus the table read and arithmetic stages
//    and the output register.
//  - Table: two banks (even and odd entries) so the four grid corners of a
//    query are read together at two read ports per bank. Writes go in
//    at the same stage as reads, so items act in arrival order.
//  - Reset clears all valid flags and loads the default grid registers;
//    the table is undefined until written, and no clearing pass runs.
//  - Receiver stall: the output register holds; the pipeline keeps moving
//    while its tail holds no result, then freezes and stalls the input.
`default_nettype none

module antenna_pcv_grid_interpolator #(
    parameter int NUM_BANDS        = apgi_pkg::NUM_BANDS_DEF,
    parameter int ENTRIES_PER_BAND = apgi_pkg::ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_operation,
    input  wire logic        [apgi_pkg::BAND_W-1:0] i_band,
    input  wire logic        [apgi_pkg::IDX_W-1:0]  i_entry_index,
    input  wire logic signed [apgi_pkg::VAL_W-1:0]  i_entry_value,
    input  wire logic        [apgi_pkg::AZ_W-1:0]   i_azimuth,
    input  wire logic        [apgi_pkg::ZE_W-1:0]   i_zenith,
    // results
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed      [apgi_pkg::VAL_W-1:0]  o_correction,
    output logic                                   o_status,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic        [apgi_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic        [apgi_pkg::CDAT_W-1:0] i_cfg_data
);

    localparam int ROWB   = (ENTRIES_PER_BAND + 1) / 2;
    localparam int BDEPTH = NUM_BANDS * ROWB;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int EW     = $clog2(ENTRIES_PER_BAND);
    localparam int DS     = apgi_pkg::DQ_W;
    localparam int FS     = apgi_pkg::FQ_W;
    localparam int FNW    = apgi_pkg::FN_W;

    // Divider section stage
    typedef struct packed {
        logic              vld;
        logic              qry;
        logic              bad;
        logic              lin;
        logic [3:0]        band;
        logic [10:0]       widx;
        logic signed [15:0] wval;
        logic [4:0]        li;
        logic [10:0]       lf;
        logic [DS-1:0]     za;
        logic [DS-1:0]     zq;
        logic [DS-1:0]     na;
        logic [DS-1:0]     nq;
        logic [DS-1:0]     aa;
        logic [DS-1:0]     aq;
    } t_dv;

    typedef struct packed {
        logic              vld;
        logic              qry;
        logic              bad;
        logic              lin;
        logic [3:0]        band;
        logic [10:0]       widx;
        logic signed [15:0] wval;
        logic [16:0]       ize;
        logic [16:0]       n;
        logic [14:0]       rz;
        logic [16:0]       ra;
        logic [33:0]       base;
    } t_m1;

    typedef struct packed {
        logic              vld;
        logic              qry;
        logic              bad;
        logic              lin;
        logic [3:0]        band;
        logic [10:0]       widx;
        logic signed [15:0] wval;
        logic [EW-1:0]     i00;
        logic [EW-1:0]     i10;
        logic [14:0]       rz;
        logic [16:0]       ra;
    } t_m2;

    typedef struct packed {
        logic        vld;
        logic        qry;
        logic        bad;
        logic        lin;
        logic [14:0] rz;
        logic [16:0] ra;
        logic        plo;
        logic        phi;
    } t_m3;

    typedef struct packed {
        logic               vld;
        logic               qry;
        logic               bad;
        logic signed [31:0] p00;
        logic signed [31:0] p01;
        logic signed [31:0] p10;
        logic signed [31:0] p11;
        logic [16:0]        wa0;
        logic [16:0]        wa1;
        logic [31:0]        den;
    } t_m4;

    typedef struct packed {
        logic               vld;
        logic               qry;
        logic               bad;
        logic signed [32:0] slo;
        logic signed [32:0] shi;
        logic [16:0]        wa0;
        logic [16:0]        wa1;
        logic [31:0]        den;
    } t_m5;

    typedef struct packed {
        logic               vld;
        logic               qry;
        logic               bad;
        logic signed [50:0] mlo;
        logic signed [50:0] mhi;
        logic [31:0]        den;
    } t_m6;

    typedef struct packed {
        logic               vld;
        logic               qry;
        logic               bad;
        logic signed [51:0] num;
        logic [31:0]        den;
    } t_m7;

    typedef struct packed {
        logic           vld;
        logic           qry;
        logic           bad;
        logic [FNW-1:0] rem;
        logic [FS-1:0]  q;
        logic [32:0]    d;
    } t_fd;

    // Configuration registers
    logic [14:0] r_zs, r_ze, r_zstep;
    logic [16:0] r_astep;

    // Pipeline registers
    t_dv r_dv [0:DS];
    t_dv n_dv [0:DS];
    t_m1 r_m1, n_m1;
    t_m2 r_m2, n_m2;
    t_m3 r_m3, n_m3;
    t_m4 r_m4, n_m4;
    t_m5 r_m5, n_m5;
    t_m6 r_m6, n_m6;
    t_m7 r_m7, n_m7;
    t_fd r_fd [0:FS];
    t_fd n_fd [0:FS];

    logic               r_out_valid;
    logic signed [15:0] r_correction;
    logic               r_status;

    logic adv;

    // Stage 0 helpers
    logic [14:0] s0_dz, s0_dn;
    logic [4:0]  s0_q5;
    logic [14:0] s0_f;
    logic        s0_lin, s0_band_bad;

    // Stage M1 helpers
    logic [16:0] m1_iaz, m1_n;

    // Stage M2 helpers
    logic [34:0] m2_i00, m2_i10, m2_imax;

    // Bank access
    logic           ram_we_ev, ram_we_od;
    logic [BAW-1:0] ram_waddr;
    logic [31:0]    rb_r, rb_w;
    logic [31:0]    ev_lo32, od_lo32, ev_hi32, od_hi32, wa32;
    logic [15:0]    ev_a, ev_b, od_a, od_b;

    // Stage M3 helpers
    logic signed [15:0] v00, v01, v10, v11;
    logic [14:0]        zse, wz0;
    logic [16:0]        ase;
    logic               zf3, af3;

    // Stage M8 helpers
    logic [52:0] nn;

    // Output helpers
    logic signed [17:0] res18;
    logic signed [15:0] res_sat;

    // Configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zs    <= apgi_pkg::ZS_RST;
            r_ze    <= apgi_pkg::ZE_RST;
            r_zstep <= apgi_pkg::ZSTEP_RST;
            r_astep <= apgi_pkg::ASTEP_RST;
        end else if (i_cfg_valid) begin
            case (apgi_pkg::t_cfg_idx'(i_cfg_index))
                apgi_pkg::CFG_ZENITH_START: r_zs    <= i_cfg_data[14:0];
                apgi_pkg::CFG_ZENITH_END:   r_ze    <= i_cfg_data[14:0];
                apgi_pkg::CFG_ZENITH_STEP:  r_zstep <= i_cfg_data[14:0];
                apgi_pkg::CFG_AZIMUTH_STEP: r_astep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline moves unless a result at the tail cannot leave
    assign adv     = !(r_out_valid && i_stall && r_fd[FS].vld && r_fd[FS].qry);
    assign o_stall = !adv;

    // Stage 0: range checks, linear-mode cell, divider lane setup
    always_comb begin
        s0_lin      = (r_astep == '0);
        s0_band_bad = 32'(i_band) >= 32'(NUM_BANDS);
        s0_dz       = i_zenith - r_zs;
        s0_dn       = r_ze - r_zs;
        s0_q5       = apgi_pkg::div5(i_zenith[14:8]);
        s0_f        = i_zenith - 15'(s0_q5) * apgi_pkg::LIN_STEP;

        n_dv[0]      = '0;
        n_dv[0].vld  = i_valid;
        n_dv[0].qry  = (i_operation == apgi_pkg::OP_QUERY);
        n_dv[0].lin  = s0_lin;
        n_dv[0].band = i_band;
        n_dv[0].widx = i_entry_index;
        n_dv[0].wval = i_entry_value;
        if (i_operation == apgi_pkg::OP_QUERY) begin
            n_dv[0].bad = s0_band_bad ||
                (!s0_lin && (r_zstep == '0 || r_ze < r_zs || i_zenith < r_zs ||
                             i_azimuth > apgi_pkg::FULL_TURN));
        end else begin
            n_dv[0].bad = s0_band_bad ||
                32'(i_entry_index) >= 32'(ENTRIES_PER_BAND);
        end
        // clamp at the last linear point
        if (s0_q5 >= apgi_pkg::LIN_LAST) begin
            n_dv[0].li = apgi_pkg::LIN_LAST;
            n_dv[0].lf = '0;
        end else begin
            n_dv[0].li = s0_q5;
            n_dv[0].lf = s0_f[10:0];
        end
        n_dv[0].zq = DS'(s0_dz);
        n_dv[0].nq = DS'(s0_dn);
        n_dv[0].aq = i_azimuth;
    end

    // Divider stages: zenith cell, zenith point count, azimuth cell
    for (genvar k = 1; k <= DS; k++) begin : g_div
        always_comb begin
            n_dv[k] = r_dv[k-1];
            {n_dv[k].za, n_dv[k].zq} =
                apgi_pkg::div_step(r_dv[k-1].za, r_dv[k-1].zq, DS'(r_zstep));
            {n_dv[k].na, n_dv[k].nq} =
                apgi_pkg::div_step(r_dv[k-1].na, r_dv[k-1].nq, DS'(r_zstep));
            {n_dv[k].aa, n_dv[k].aq} =
                apgi_pkg::div_step(r_dv[k-1].aa, r_dv[k-1].aq, r_astep);
        end
    end

    // M1: pick mode operands, zenith range check, azimuth row base
    always_comb begin
        n_m1      = '0;
        n_m1.vld  = r_dv[DS].vld;
        n_m1.qry  = r_dv[DS].qry;
        n_m1.lin  = r_dv[DS].lin;
        n_m1.band = r_dv[DS].band;
        n_m1.widx = r_dv[DS].widx;
        n_m1.wval = r_dv[DS].wval;
        if (r_dv[DS].lin) begin
            n_m1.ize = 17'(r_dv[DS].li);
            n_m1.rz  = 15'(r_dv[DS].lf);
            n_m1.ra  = '0;
            m1_iaz   = '0;
            m1_n     = 17'd1;
        end else begin
            n_m1.ize = r_dv[DS].zq;
            n_m1.rz  = r_dv[DS].za[14:0];
            n_m1.ra  = r_dv[DS].aa;
            m1_iaz   = r_dv[DS].aq;
            m1_n     = r_dv[DS].nq + 17'd1;
        end
        n_m1.n    = m1_n;
        n_m1.base = 34'(m1_iaz) * 34'(m1_n);
        n_m1.bad  = r_dv[DS].bad ||
            (r_dv[DS].qry && !r_dv[DS].lin &&
             (r_dv[DS].zq > r_dv[DS].nq ||
              (r_dv[DS].zq == r_dv[DS].nq && r_dv[DS].za != '0)));
    end

    // M2: corner indices and table bound check
    always_comb begin
        m2_i00  = 35'(r_m1.base) + 35'(r_m1.ize);
        m2_i10  = m2_i00 + 35'(r_m1.n);
        m2_imax = m2_i00 + ((r_m1.ra != '0) ? 35'(r_m1.n) : 35'd0) +
                  35'(r_m1.rz != '0);
        n_m2      = '0;
        n_m2.vld  = r_m1.vld;
        n_m2.qry  = r_m1.qry;
        n_m2.lin  = r_m1.lin;
        n_m2.band = r_m1.band;
        n_m2.widx = r_m1.widx;
        n_m2.wval = r_m1.wval;
        n_m2.i00  = m2_i00[EW-1:0];
        n_m2.i10  = m2_i10[EW-1:0];
        n_m2.rz   = r_m1.rz;
        n_m2.ra   = r_m1.ra;
        n_m2.bad  = r_m1.bad ||
            (r_m1.qry && m2_imax >= 35'(ENTRIES_PER_BAND));
    end

    // Bank addressing: even entries in one bank, odd in the other
    always_comb begin
        rb_r    = 32'(r_m2.band) * 32'(ROWB);
        rb_w    = rb_r;
        ev_lo32 = rb_r + 32'(r_m2.i00[EW-1:1]) + 32'(r_m2.i00[0]);
        od_lo32 = rb_r + 32'(r_m2.i00[EW-1:1]);
        ev_hi32 = rb_r + 32'(r_m2.i10[EW-1:1]) + 32'(r_m2.i10[0]);
        od_hi32 = rb_r + 32'(r_m2.i10[EW-1:1]);
        wa32    = rb_w + 32'(r_m2.widx[10:1]);
        ram_waddr = wa32[BAW-1:0];
        ram_we_ev = adv && r_m2.vld && !r_m2.qry && !r_m2.bad && !r_m2.widx[0];
        ram_we_od = adv && r_m2.vld && !r_m2.qry && !r_m2.bad && r_m2.widx[0];
    end

    apgi_ram #(
        .WIDTH (16),
        .DEPTH (BDEPTH)
    ) u_ram_even (
        .i_clk     (i_clk),
        .i_we      (ram_we_ev),
        .i_waddr   (ram_waddr),
        .i_wdata   (r_m2.wval),
        .i_re      (adv),
        .i_raddr_a (ev_lo32[BAW-1:0]),
        .i_raddr_b (ev_hi32[BAW-1:0]),
        .o_rdata_a (ev_a),
        .o_rdata_b (ev_b)
    );

    apgi_ram #(
        .WIDTH (16),
        .DEPTH (BDEPTH)
    ) u_ram_odd (
        .i_clk     (i_clk),
        .i_we      (ram_we_od),
        .i_waddr   (ram_waddr),
        .i_wdata   (r_m2.wval),
        .i_re      (adv),
        .i_raddr_a (od_lo32[BAW-1:0]),
        .i_raddr_b (od_hi32[BAW-1:0]),
        .o_rdata_a (od_a),
        .o_rdata_b (od_b)
    );

    // M3 metadata rides alongside the bank read
    always_comb begin
        n_m3     = '0;
        n_m3.vld = r_m2.vld;
        n_m3.qry = r_m2.qry;
        n_m3.bad = r_m2.bad;
        n_m3.lin = r_m2.lin;
        n_m3.rz  = r_m2.rz;
        n_m3.ra  = r_m2.ra;
        n_m3.plo = r_m2.i00[0];
        n_m3.phi = r_m2.i10[0];
    end

    // M4: sort corners, drop unused neighbors, zenith weighting
    always_comb begin
        zf3 = (r_m3.rz != '0);
        af3 = (r_m3.ra != '0);
        v00 = $signed(r_m3.plo ? od_a : ev_a);
        v01 = $signed(r_m3.plo ? ev_a : od_a);
        v10 = $signed(r_m3.phi ? od_b : ev_b);
        v11 = $signed(r_m3.phi ? ev_b : od_b);
        if (!zf3) begin
            v01 = '0;
        end
        if (!af3) begin
            v10 = '0;
        end
        if (!(zf3 && af3)) begin
            v11 = '0;
        end
        zse = r_m3.lin ? apgi_pkg::LIN_STEP : r_zstep;
        ase = r_m3.lin ? 17'd1 : r_astep;
        wz0 = zse - r_m3.rz;

        n_m4     = '0;
        n_m4.vld = r_m3.vld;
        n_m4.qry = r_m3.qry;
        n_m4.bad = r_m3.bad;
        n_m4.p00 = v00 * $signed({1'b0, wz0});
        n_m4.p01 = v01 * $signed({1'b0, r_m3.rz});
        n_m4.p10 = v10 * $signed({1'b0, wz0});
        n_m4.p11 = v11 * $signed({1'b0, r_m3.rz});
        n_m4.wa0 = ase - r_m3.ra;
        n_m4.wa1 = r_m3.ra;
        n_m4.den = 32'(zse) * 32'(ase);
    end

    // M5: row sums
    always_comb begin
        n_m5     = '0;
        n_m5.vld = r_m4.vld;
        n_m5.qry = r_m4.qry;
        n_m5.bad = r_m4.bad;
        n_m5.slo = 33'(r_m4.p00) + 33'(r_m4.p01);
        n_m5.shi = 33'(r_m4.p10) + 33'(r_m4.p11);
        n_m5.wa0 = r_m4.wa0;
        n_m5.wa1 = r_m4.wa1;
        n_m5.den = r_m4.den;
    end

    // M6: azimuth weighting
    always_comb begin
        n_m6     = '0;
        n_m6.vld = r_m5.vld;
        n_m6.qry = r_m5.qry;
        n_m6.bad = r_m5.bad;
        n_m6.mlo = r_m5.slo * $signed({1'b0, r_m5.wa0});
        n_m6.mhi = r_m5.shi * $signed({1'b0, r_m5.wa1});
        n_m6.den = r_m5.den;
    end

    // M7: numerator
    always_comb begin
        n_m7     = '0;
        n_m7.vld = r_m6.vld;
        n_m7.qry = r_m6.qry;
        n_m7.bad = r_m6.bad;
        n_m7.num = 52'(r_m6.mlo) + 52'(r_m6.mhi);
        n_m7.den = r_m6.den;
    end

    // Rounding dividend: 2*num + den, offset by 32769*(2*den) to stay positive
    always_comb begin
        nn = {r_m7.num, 1'b0} + {5'b0, r_m7.den, 16'b0} + 53'(r_m7.den) +
             {20'b0, r_m7.den, 1'b0};
        n_fd[0]     = '0;
        n_fd[0].vld = r_m7.vld;
        n_fd[0].qry = r_m7.qry;
        n_fd[0].bad = r_m7.bad;
        n_fd[0].rem = nn[FNW-1:0];
        n_fd[0].d   = {r_m7.den, 1'b0};
    end

    // Final divider, quotient MSB first
    for (genvar k = 1; k <= FS; k++) begin : g_fdiv
        localparam int B = FS - k;
        logic [FNW-1:0] ds;
        always_comb begin
            ds      = FNW'(r_fd[k-1].d) << B;
            n_fd[k] = r_fd[k-1];
            if (r_fd[k-1].rem >= ds) begin
                n_fd[k].rem  = r_fd[k-1].rem - ds;
                n_fd[k].q[B] = 1'b1;
            end
        end
    end

    // Remove offset and saturate
    always_comb begin
        res18 = $signed({1'b0, r_fd[FS].q}) - apgi_pkg::Q_OFFSET;
        if (res18 > 18'sd32767) begin
            res_sat = 16'sh7fff;
        end else if (res18 < -18'sd32768) begin
            res_sat = -16'sh8000;
        end else begin
            res_sat = res18[15:0];
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DS; k++) begin
                r_dv[k].vld <= 1'b0;
            end
            for (int k = 0; k <= FS; k++) begin
                r_fd[k].vld <= 1'b0;
            end
            r_m1.vld <= 1'b0;
            r_m2.vld <= 1'b0;
            r_m3.vld <= 1'b0;
            r_m4.vld <= 1'b0;
            r_m5.vld <= 1'b0;
            r_m6.vld <= 1'b0;
            r_m7.vld <= 1'b0;
        end else if (adv) begin
            r_dv <= n_dv;
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            r_m4 <= n_m4;
            r_m5 <= n_m5;
            r_m6 <= n_m6;
            r_m7 <= n_m7;
            r_fd <= n_fd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_fd[FS].vld && r_fd[FS].qry) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_fd[FS].vld && r_fd[FS].qry) begin
            r_correction <= r_fd[FS].bad ? 16'sd0 : res_sat;
            r_status     <= r_fd[FS].bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_correction = r_correction;
    assign o_status     = r_status;

endmodule

`default_nettype wire

// ----- sv/apgi_checker.sv -----
// Port-level checker for the grid interpolator, bound to the top level.
// Depends on the top-level port list only.
`default_nettype none

module apgi_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_stall,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic signed [15:0] o_correction,
    input wire logic               o_status
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Out-of-grid results carry a zero correction
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_correction == 16'sd0)
        else $error("nonzero correction with out-of-grid status");

    // Input is held back only by a waiting, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_correction) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind antenna_pcv_grid_interpolator apgi_checker u_apgi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_stall      (i_stall),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .o_correction (o_correction),
    .o_status     (o_status)
);

`default_nettype wire
